/* rtl/core/digitizer_event_framer_defines.svh */
// assertion macros used by the framer checker
`ifndef DIGITIZER_EVENT_FRAMER_DEFINES_SVH
`define DIGITIZER_EVENT_FRAMER_DEFINES_SVH

// consequent must hold in the cycle after the antecedent
`define DEF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// consequent must hold after a delay from the antecedent
`define DEF_ASSERT_AFTER2(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

/* rtl/core/def_pkg.sv */
// shared types and constants of the digitizer event framer
package def_pkg;

  localparam int CHANNELS_DEF    = 8;
  localparam int MAX_SAMPLES_DEF = 4096;

  localparam int MASK_W    = 8;
  localparam int TIME_W    = 48;
  localparam int SPC_W     = 13;
  localparam int SMP_W     = 18;
  localparam int WORD_W    = 32;
  localparam int STAMP_W   = 31;
  localparam int PER_W     = 8;
  localparam int CLAMP_W   = 14;
  localparam int NCH_W     = 4;
  localparam int DIV_CNT_W = 6;

  localparam logic [DIV_CNT_W-1:0] DIV_STEPS  = DIV_CNT_W'(TIME_W);
  localparam logic [PER_W-1:0]     PERIOD_RST = 8'd10;
  localparam logic [WORD_W-1:0]    HDR_MARK   = 32'hA000_0000;
  localparam int CH_OVERHEAD = 2;
  localparam int EV_OVERHEAD = 4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_HDR_TOTAL,
    ST_HDR_MASK,
    ST_HDR_COUNT,
    ST_HDR_STAMP,
    ST_CH_SIZE,
    ST_CH_STAMP,
    ST_DATA
  } def_state_e;

  typedef enum logic [2:0] {
    W_TOTAL,
    W_MASK,
    W_COUNT,
    W_HSTAMP,
    W_SIZE,
    W_CSTAMP,
    W_DATA
  } def_word_e;

  typedef struct packed {
    logic      accept;
    logic      div_step;
    logic      emit;
    def_word_e sel;
  } def_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
    logic chan_open;
    logic pair_zero;
    logic pairs_zero;
  } def_sts_t;

endpackage

/* rtl/core/def_in_if.sv */
// input request channel: start items and sample pairs
interface def_in_if import def_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic [MASK_W-1:0]       channel_mask;
  logic [TIME_W-1:0]       time_ns;
  logic [SPC_W-1:0]        samples_per_channel;
  logic signed [SMP_W-1:0] sample_first;
  logic signed [SMP_W-1:0] sample_second;

  modport source (
    output valid, mode, channel_mask, time_ns, samples_per_channel,
           sample_first, sample_second,
    input  ready
  );
  modport sink (
    input  valid, mode, channel_mask, time_ns, samples_per_channel,
           sample_first, sample_second,
    output ready
  );
endinterface

/* rtl/core/def_out_if.sv */
// output request channel: formatted event words
interface def_out_if import def_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] out_word;
  logic              last_word;

  modport source (
    output valid, out_word, last_word,
    input  ready
  );
  modport sink (
    input  valid, out_word, last_word,
    output ready
  );
endinterface

/* rtl/core/def_ctrl.sv */
// framer controller: sequences division and word emission
module def_ctrl import def_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_mode_i,
  output logic     in_ready_o,
  input  def_sts_t sts_i,
  output def_cmd_t cmd_o
);

  def_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    cmd_o.accept   = 1'b0;
    cmd_o.div_step = 1'b0;
    cmd_o.emit     = 1'b0;
    cmd_o.sel      = W_TOTAL;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (!in_mode_i) begin
            state_d = ST_DIV;
          end else if (sts_i.chan_open) begin
            state_d = sts_i.pair_zero ? ST_CH_SIZE : ST_DATA;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_HDR_TOTAL;
        end
      end
      ST_HDR_TOTAL: begin
        cmd_o.sel = W_TOTAL;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_HDR_MASK;
        end
      end
      ST_HDR_MASK: begin
        cmd_o.sel = W_MASK;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_HDR_COUNT;
        end
      end
      ST_HDR_COUNT: begin
        cmd_o.sel = W_COUNT;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_HDR_STAMP;
        end
      end
      ST_HDR_STAMP: begin
        cmd_o.sel = W_HSTAMP;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_CH_SIZE: begin
        cmd_o.sel = W_SIZE;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_CH_STAMP;
        end
      end
      ST_CH_STAMP: begin
        cmd_o.sel = W_CSTAMP;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = sts_i.pairs_zero ? ST_IDLE : ST_DATA;
        end
      end
      ST_DATA: begin
        cmd_o.sel = W_DATA;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/def_dp.sv */
// framer datapath: event state, stamp divider and output word register
module def_dp import def_pkg::*; #(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [PER_W-1:0]        cfg_wdata_i,
  input  logic                    mode_i,
  input  logic [MASK_W-1:0]       channel_mask_i,
  input  logic [TIME_W-1:0]       time_ns_i,
  input  logic [SPC_W-1:0]        samples_per_channel_i,
  input  logic signed [SMP_W-1:0] sample_first_i,
  input  logic signed [SMP_W-1:0] sample_second_i,
  input  def_cmd_t                cmd_i,
  output def_sts_t                sts_o,
  def_out_if.source               word_o
);

  localparam int PAIRS_MAX = MAX_SAMPLES / 2;
  localparam int PW        = (PAIRS_MAX < 2) ? 1 : $clog2(PAIRS_MAX + 1);
  localparam int TOT_W     = NCH_W + PW + 2;

  function automatic logic [CLAMP_W-1:0] clamp_smp(input logic signed [SMP_W-1:0] s);
    clamp_smp = s[SMP_W-1] ? '0 : s[CLAMP_W-1:0];
  endfunction

  // control and event state
  logic [PER_W-1:0]     per_q, per_d;
  logic [WORD_W-1:0]    count_q, count_d;
  logic [STAMP_W-1:0]   stamp_q, stamp_d;
  logic [PW-1:0]        pairs_q, pairs_d;
  logic [PW-1:0]        pidx_q, pidx_d;
  logic [NCH_W-1:0]     chleft_q, chleft_d;
  logic [DIV_CNT_W-1:0] dcnt_q, dcnt_d;
  logic                 oval_q, oval_d;

  // payload
  logic [MASK_W-1:0]    mask_q, mask_d;
  logic [TOT_W-1:0]     total_q, total_d;
  logic [TIME_W-1:0]    dvd_q, dvd_d;
  logic [PER_W-1:0]     rem_q, rem_d;
  logic [PER_W-1:0]     dvs_q, dvs_d;
  logic [CLAMP_W-1:0]   smp1_q, smp1_d, smp2_q, smp2_d;
  logic [WORD_W-1:0]    oword_q, oword_d;
  logic                 olast_q, olast_d;

  logic [MASK_W-1:0] chan_bits, mask_in;
  logic [NCH_W-1:0]  nch;
  logic [31:0]       spc_ext, spc_sat;
  logic [PW-1:0]     pairs_in;
  logic [PER_W:0]    trial, diff;
  logic              ge;
  logic [PW:0]       pnext;
  logic              pdone;
  logic              out_free;

  always_comb begin
    for (int i = 0; i < MASK_W; i++) begin
      chan_bits[i] = (i < CHANNELS);
    end
  end

  assign mask_in = channel_mask_i & chan_bits;

  always_comb begin
    nch = '0;
    for (int i = 0; i < MASK_W; i++) begin
      nch = nch + NCH_W'(mask_in[i]);
    end
  end

  assign spc_ext  = 32'(samples_per_channel_i);
  assign spc_sat  = (spc_ext > 32'(MAX_SAMPLES)) ? 32'(MAX_SAMPLES) : spc_ext;
  assign pairs_in = spc_sat[PW:1];

  // one quotient bit per step
  assign trial = {rem_q, dvd_q[TIME_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});

  assign pnext    = {1'b0, pidx_q} + (PW+1)'(1);
  assign pdone    = (pnext >= {1'b0, pairs_q});
  assign out_free = !oval_q || word_o.ready;

  always_comb begin
    per_d    = per_q;
    count_d  = count_q;
    stamp_d  = stamp_q;
    pairs_d  = pairs_q;
    pidx_d   = pidx_q;
    chleft_d = chleft_q;
    dcnt_d   = dcnt_q;
    mask_d   = mask_q;
    total_d  = total_q;
    dvd_d    = dvd_q;
    rem_d    = rem_q;
    dvs_d    = dvs_q;
    smp1_d   = smp1_q;
    smp2_d   = smp2_q;
    oword_d  = oword_q;
    olast_d  = olast_q;
    oval_d   = word_o.ready ? 1'b0 : oval_q;

    if (cfg_we_i) begin
      per_d = cfg_wdata_i;
    end

    if (cmd_i.accept) begin
      if (!mode_i) begin
        count_d  = count_q + WORD_W'(1);
        mask_d   = mask_in;
        pairs_d  = pairs_in;
        pidx_d   = '0;
        chleft_d = nch;
        total_d  = TOT_W'(nch) * (TOT_W'(pairs_in) + TOT_W'(CH_OVERHEAD))
                   + TOT_W'(EV_OVERHEAD);
        dvd_d    = time_ns_i;
        rem_d    = '0;
        dvs_d    = (per_q == '0) ? PER_W'(1) : per_q;
        dcnt_d   = DIV_STEPS;
      end else begin
        smp1_d = clamp_smp(sample_first_i);
        smp2_d = clamp_smp(sample_second_i);
      end
    end

    if (cmd_i.div_step) begin
      rem_d   = ge ? diff[PER_W-1:0] : trial[PER_W-1:0];
      dvd_d   = {dvd_q[TIME_W-2:0], 1'b0};
      stamp_d = {stamp_q[STAMP_W-2:0], ge};
      dcnt_d  = dcnt_q - DIV_CNT_W'(1);
    end

    if (cmd_i.emit) begin
      oval_d = 1'b1;
      unique case (cmd_i.sel)
        W_TOTAL: begin
          oword_d = HDR_MARK | WORD_W'(total_q);
          olast_d = 1'b0;
        end
        W_MASK: begin
          oword_d = WORD_W'(mask_q);
          olast_d = 1'b0;
        end
        W_COUNT: begin
          oword_d = count_q;
          olast_d = 1'b0;
        end
        W_HSTAMP: begin
          oword_d = WORD_W'(stamp_q);
          olast_d = (chleft_q == '0);
        end
        W_SIZE: begin
          oword_d = WORD_W'(pairs_q) + WORD_W'(CH_OVERHEAD);
          olast_d = 1'b0;
        end
        W_CSTAMP: begin
          oword_d = WORD_W'(stamp_q);
          olast_d = (pairs_q == '0) && (chleft_q == NCH_W'(1));
          if (pairs_q == '0) begin
            chleft_d = chleft_q - NCH_W'(1);
          end
        end
        W_DATA: begin
          oword_d = {2'b00, smp2_q, 2'b00, smp1_q};
          olast_d = pdone && (chleft_q == NCH_W'(1));
          if (pdone) begin
            pidx_d   = '0;
            chleft_d = chleft_q - NCH_W'(1);
          end else begin
            pidx_d = pnext[PW-1:0];
          end
        end
        default: begin
          oword_d = '0;
          olast_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      per_q    <= PERIOD_RST;
      count_q  <= '0;
      stamp_q  <= '0;
      pairs_q  <= '0;
      pidx_q   <= '0;
      chleft_q <= '0;
      dcnt_q   <= '0;
      oval_q   <= 1'b0;
    end else begin
      per_q    <= per_d;
      count_q  <= count_d;
      stamp_q  <= stamp_d;
      pairs_q  <= pairs_d;
      pidx_q   <= pidx_d;
      chleft_q <= chleft_d;
      dcnt_q   <= dcnt_d;
      oval_q   <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q  <= mask_d;
    total_q <= total_d;
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    dvs_q   <= dvs_d;
    smp1_q  <= smp1_d;
    smp2_q  <= smp2_d;
    oword_q <= oword_d;
    olast_q <= olast_d;
  end

  assign sts_o.div_last   = (dcnt_q == DIV_CNT_W'(1));
  assign sts_o.out_free   = out_free;
  assign sts_o.chan_open  = (chleft_q != '0);
  assign sts_o.pair_zero  = (pidx_q == '0);
  assign sts_o.pairs_zero = (pairs_q == '0);

  assign word_o.valid     = oval_q;
  assign word_o.out_word  = oword_q;
  assign word_o.last_word = olast_q;

endmodule

/* rtl/core/digitizer_event_framer.sv */
// top level of the digitizer event framer
//
//  channel  dir  handshake          contents
//  evt_i    in   valid/ready        start item (mode 0) or one sample pair (mode 1)
//  word_o   out  valid/ready        32-bit event words, last_word on the final one
//  cfg      in   cfg_we_i           clock period in ns, no read-back
//
// a start request is accepted, then the restoring divider yields one quotient bit
// per cycle for the stamp, then the four header words are emitted; a sample pair
// request is accepted and emits one to three words, none if no channel is open
// an output stall holds the controller in its emit state; the last word of a
// request waits in the output register while the next request is accepted
// reset clears the event state and sets the clock period to 10, no clearing pass
module digitizer_event_framer import def_pkg::*; #(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [PER_W-1:0] cfg_wdata_i,
  def_in_if.sink           evt_i,
  def_out_if.source        word_o
);

  // command and status between controller and datapath
  def_cmd_t cmd;
  def_sts_t sts;
  logic     in_ready;

  // controller sees the handshake, the mode bit and the datapath status
  def_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (evt_i.valid),
    .in_mode_i  (evt_i.mode),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign evt_i.ready = in_ready;

  // datapath holds event state, the stamp divider and the output register
  def_dp #(
    .CHANNELS    (CHANNELS),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .mode_i                (evt_i.mode),
    .channel_mask_i        (evt_i.channel_mask),
    .time_ns_i             (evt_i.time_ns),
    .samples_per_channel_i (evt_i.samples_per_channel),
    .sample_first_i        (evt_i.sample_first),
    .sample_second_i       (evt_i.sample_second),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .word_o                (word_o)
  );

endmodule

/* rtl/core/def_chk.sv */
// port-level checker for the framer, bound to the top level
`include "digitizer_event_framer_defines.svh"

module def_chk import def_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              in_mode_i,
  input logic              word_valid_i,
  input logic              word_ready_i,
  input logic [WORD_W-1:0] word_data_i,
  input logic              word_last_i
);

  logic start_acc;
  logic word_stall;

  assign start_acc  = in_valid_i && in_ready_i && !in_mode_i;
  assign word_stall = word_valid_i && !word_ready_i;

  `DEF_ASSERT_NEXT(a_word_hold, clk_i, rst_ni, word_stall, word_valid_i && $stable(word_data_i) && $stable(word_last_i), "stalled word changed")

  `DEF_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start_acc, !in_ready_i, "request taken during stamp division")

  `DEF_ASSERT_AFTER2(a_div_busy, clk_i, rst_ni, start_acc, !in_ready_i, "divider finished too early")

  `DEF_ASSERT_NEXT(a_no_early_word, clk_i, rst_ni, start_acc && !word_stall, !word_valid_i, "header word before stamp ready")

endmodule

bind digitizer_event_framer def_chk u_def_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (evt_i.valid),
  .in_ready_i   (evt_i.ready),
  .in_mode_i    (evt_i.mode),
  .word_valid_i (word_o.valid),
  .word_ready_i (word_o.ready),
  .word_data_i  (word_o.out_word),
  .word_last_i  (word_o.last_word)
);

/* tb/tb_digitizer_event_framer.sv */
// testbench of the digitizer event framer: predicted event word stream checked word by word
`timescale 1ns / 100ps

module tb_digitizer_event_framer;
  import def_pkg::*;

  localparam int PHASE_ITEMS   = 57;    // requests per random phase
  localparam int SETTLE_CYCLES = 16;    // covers a dropped pair request still in flight
  localparam int IDLE_LIMIT    = 2000;  // cycles with no handshake on either side

  // request kinds carried on the mode field
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_PAIR  = 1'b1;

  // one input request as driven on the event channel
  typedef struct {
    logic                    mode;
    logic [MASK_W-1:0]       channel_mask;
    logic [TIME_W-1:0]       time_ns;
    logic [SPC_W-1:0]        samples_per_channel;
    logic signed [SMP_W-1:0] sample_first;
    logic signed [SMP_W-1:0] sample_second;
  } evt_req_t;

  // one expected word of the event stream
  typedef struct {
    logic [WORD_W-1:0] word;
    logic              last;
  } frame_word_t;

  // tracks the framer state and the words it still owes
  class event_frame_tracker;
    localparam int MAX_PRINTS = 30;

    logic [PER_W-1:0]   period;
    logic [31:0]        event_count;
    logic [STAMP_W-1:0] stamp;
    logic [11:0]        pairs;
    logic [11:0]        pair_idx;
    logic [NCH_W-1:0]   chans_left;
    frame_word_t        pending_words[$];
    int                 errors;

    function new();
      period      = PERIOD_RST;
      event_count = '0;
      stamp       = '0;
      pairs       = '0;
      pair_idx    = '0;
      chans_left  = '0;
      errors      = 0;
    endfunction

    function void set_period(logic [PER_W-1:0] p);
      period = p;
    endfunction

    function void expect_word(logic [WORD_W-1:0] word, logic last);
      frame_word_t w;
      w.word = word;
      w.last = last;
      pending_words.insert(pending_words.size(), w);
    endfunction

    // negative samples read as zero, then the low bits are kept
    function logic [CLAMP_W-1:0] clamp_sample(logic signed [SMP_W-1:0] s);
      return s[SMP_W-1] ? '0 : s[CLAMP_W-1:0];
    endfunction

    // works out the words caused by one accepted request
    function void note_request(evt_req_t r);
      logic [MASK_W-1:0] mask;
      logic [SPC_W-1:0]  spc;
      logic [TIME_W-1:0] quotient;
      logic [WORD_W-1:0] total;
      logic [WORD_W-1:0] data;
      logic              ends;
      int unsigned       nch;
      if (r.mode == MODE_START) begin
        mask = r.channel_mask & MASK_W'((1 << CHANNELS_DEF) - 1);
        nch = $countones(mask);
        spc = (r.samples_per_channel > MAX_SAMPLES_DEF) ? SPC_W'(MAX_SAMPLES_DEF)
                                                        : r.samples_per_channel;
        quotient = r.time_ns / TIME_W'((period == 0) ? 1 : period);
        event_count++;
        stamp      = quotient[STAMP_W-1:0];
        pairs      = 12'(spc >> 1);
        pair_idx   = '0;
        chans_left = NCH_W'(nch);
        total = WORD_W'(nch * (32'(pairs) + CH_OVERHEAD) + EV_OVERHEAD);
        expect_word(total | HDR_MARK, 1'b0);
        expect_word(WORD_W'(mask), 1'b0);
        expect_word(event_count, 1'b0);
        expect_word(WORD_W'(stamp), nch == 0);
      end else if (chans_left != 0) begin
        ends = 1'b0;
        if (pair_idx == 0) begin
          ends = (pairs == 0) && (chans_left == 1);
          expect_word(WORD_W'(pairs) + CH_OVERHEAD, 1'b0);
          expect_word(WORD_W'(stamp), ends);
        end
        if (pairs != 0) begin
          data = WORD_W'(clamp_sample(r.sample_first))
               | (WORD_W'(clamp_sample(r.sample_second)) << 16);
          pair_idx++;
          ends = (pair_idx >= pairs) && (chans_left == 1);
          expect_word(data, ends);
        end
        if (pair_idx >= pairs) begin
          pair_idx = '0;
          chans_left--;
        end
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task check_word(logic [WORD_W-1:0] word, logic last);
      frame_word_t want;
      if (pending_words.size() == 0) begin
        report($sformatf("word %h last %b with none expected", word, last));
      end else begin
        want = pending_words.pop_front();
        if (word !== want.word) report($sformatf("word %h, expected %h", word, want.word));
        if (last !== want.last) report($sformatf("last %b on word %h, expected %b",
                                                 last, word, want.last));
      end
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [PER_W-1:0]   cfg_wdata;
  logic               allow_idle;
  int                 stall_left;
  int                 quiet_cycles;
  logic [PER_W-1:0]   period_plan [6];
  event_frame_tracker tracker;

  def_in_if  evt_if ();
  def_out_if word_if ();

  digitizer_event_framer u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .evt_i       (evt_if),
    .word_o      (word_if)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // sample values weighted toward the clamp and wrap corners
  function automatic logic signed [SMP_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(SMP_W-1){1'b0}}};
      1: return {1'b0, {(SMP_W-1){1'b1}}};
      2: return SMP_W'($urandom_range(16380, 16390));
      3: return -SMP_W'($urandom_range(0, 3));
      default: return SMP_W'($urandom);
    endcase
  endfunction

  // a request with every field random; the fields its mode ignores stay random
  function automatic evt_req_t noise_fields(logic mode);
    evt_req_t r;
    r.mode                = mode;
    r.channel_mask        = MASK_W'($urandom);
    r.time_ns             = TIME_W'({$urandom, $urandom});
    r.samples_per_channel = SPC_W'($urandom);
    r.sample_first        = pick_sample();
    r.sample_second       = pick_sample();
    return r;
  endfunction

  // pair requests that a start with these fields calls for
  function automatic int pairs_needed(logic [MASK_W-1:0] mask, logic [SPC_W-1:0] spc);
    int nch;
    int p;
    nch = $countones(mask & MASK_W'((1 << CHANNELS_DEF) - 1));
    p = ((spc > MAX_SAMPLES_DEF) ? MAX_SAMPLES_DEF : int'(spc)) / 2;
    return (p == 0) ? nch : nch * p;
  endfunction

  // drive one request and hold it until the handshake, with a random gap before
  task automatic send_request(input evt_req_t r);
    int gap;
    gap = (allow_idle && $urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
    if (gap != 0) begin
      evt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    evt_if.valid               <= 1'b1;
    evt_if.mode                <= r.mode;
    evt_if.channel_mask        <= r.channel_mask;
    evt_if.time_ns             <= r.time_ns;
    evt_if.samples_per_channel <= r.samples_per_channel;
    evt_if.sample_first        <= r.sample_first;
    evt_if.sample_second       <= r.sample_second;
    do @(posedge clk); while (!evt_if.ready);
    tracker.note_request(r);
  endtask

  task automatic send_start(input logic [MASK_W-1:0] mask, input logic [SPC_W-1:0] spc,
                            input logic [TIME_W-1:0] t);
    evt_req_t r;
    r = noise_fields(MODE_START);
    r.channel_mask        = mask;
    r.samples_per_channel = spc;
    r.time_ns             = t;
    send_request(r);
  endtask

  task automatic send_pair(input logic signed [SMP_W-1:0] first,
                           input logic signed [SMP_W-1:0] second);
    evt_req_t r;
    r = noise_fields(MODE_PAIR);
    r.sample_first  = first;
    r.sample_second = second;
    send_request(r);
  endtask

  // start request followed by a given number of random pair requests
  task automatic play_event(input logic [MASK_W-1:0] mask, input logic [SPC_W-1:0] spc,
                            input logic [TIME_W-1:0] t, input int count);
    send_start(mask, spc, t);
    repeat (count) send_request(noise_fields(MODE_PAIR));
  endtask

  // let the stream run dry, then write the clock period while nothing is in flight
  task automatic write_period(input logic [PER_W-1:0] p);
    evt_if.valid <= 1'b0;
    while (tracker.pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_period(p);
  endtask

  // mostly complete events with random content, some cut short or padded
  task automatic random_phase(input int quota);
    int                done_items;
    int                need;
    int                sent;
    logic [MASK_W-1:0] mask;
    logic [SPC_W-1:0]  spc;
    logic [TIME_W-1:0] t;
    done_items = 0;
    while (done_items < quota) begin
      case ($urandom_range(0, 9))
        0:       mask = '0;
        1:       mask = '1;
        default: mask = MASK_W'($urandom);
      endcase
      if ($urandom_range(0, 29) == 0) spc = SPC_W'($urandom_range(13, 8191));
      else if ($urandom_range(0, 7) == 0) spc = SPC_W'($urandom_range(0, 1));
      else spc = SPC_W'($urandom_range(2, 10));
      t = ($urandom_range(0, 3) == 0) ? TIME_W'($urandom_range(0, 5000))
                                      : TIME_W'({$urandom, $urandom});
      need = pairs_needed(mask, spc);
      case ($urandom_range(0, 9))
        0:       sent = (need == 0) ? 0 : $urandom_range(0, need - 1);  // cut off by next start
        1:       sent = need + $urandom_range(1, 3);                    // trailing pairs dropped
        default: sent = need;
      endcase
      // big events are only opened, then abandoned
      if (sent > 40) sent = $urandom_range(0, 6);
      play_event(mask, spc, t, sent);
      done_items += 1 + ((sent < need) ? sent : need);
    end
  endtask

  // output side: checks every accepted word, stalls in random bursts, watchdog
  always @(posedge clk) begin
    if (rst_n && word_if.valid && word_if.ready)
      tracker.check_word(word_if.out_word, word_if.last_word);

    if (stall_left != 0) begin
      stall_left--;
      if (stall_left == 0) word_if.ready <= 1'b1;
    end else if (allow_idle && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(1, 18);
      word_if.ready <= 1'b0;
    end

    if ((evt_if.valid && evt_if.ready) || (word_if.valid && word_if.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("tb_digitizer_event_framer: FAIL");
      $finish;
    end
  end

  initial begin
    // every input known from time zero, reset held low
    rst_n                      = 1'b0;
    cfg_we                     = 1'b0;
    cfg_wdata                  = '0;
    allow_idle                 = 1'b1;
    stall_left                 = 0;
    quiet_cycles               = 0;
    evt_if.valid               = 1'b0;
    evt_if.mode                = MODE_START;
    evt_if.channel_mask        = '0;
    evt_if.time_ns             = '0;
    evt_if.samples_per_channel = '0;
    evt_if.sample_first        = '0;
    evt_if.sample_second       = '0;
    word_if.ready              = 1'b1;
    tracker = new();

    // period settings per phase: extremes, zero divisor, random, back to reset value
    period_plan[0] = 8'd1;
    period_plan[1] = 8'd255;
    period_plan[2] = 8'd0;
    period_plan[3] = PER_W'($urandom_range(2, 254));
    period_plan[4] = PER_W'($urandom_range(2, 254));
    period_plan[5] = PERIOD_RST;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, period still at its reset value
    // pair request with no open event is dropped
    send_pair(pick_sample(), pick_sample());
    // empty mask and largest time: header alone, last on the stamp word
    send_start(8'h00, 13'd4, '1);
    // odd count of one gives zero pairs: each pair request opens a channel only
    send_start(8'h81, 13'd1, 48'd123456789);
    send_pair(pick_sample(), pick_sample());
    send_pair(pick_sample(), pick_sample());
    // one channel, sample extremes: clamp of negatives and wrap above 14 bits
    send_start(8'h01, 13'd6, '0);
    send_pair(SMP_W'(-131072), SMP_W'(131071));
    send_pair(SMP_W'(16383), SMP_W'(16384));
    send_pair(SMP_W'(-1), SMP_W'(0));
    // count above the maximum saturates; event abandoned by the next start
    send_start(8'hA5, '1, 48'h7FFF_FFFF_FFFF);
    send_pair(pick_sample(), pick_sample());
    send_pair(pick_sample(), pick_sample());
    send_start(8'hFF, 13'd4096, 48'hFFFF_FFFF_FFFF);
    // short complete event, then a trailing pair that is dropped
    send_start(8'h42, 13'd2, TIME_W'({$urandom, $urandom}));
    send_pair(pick_sample(), pick_sample());
    send_pair(pick_sample(), pick_sample());
    send_pair(pick_sample(), pick_sample());

    // random phases, one period setting each; no idling in the last one
    for (int i = 0; i < 6; i++) begin
      write_period(period_plan[i]);
      if (i == 5) allow_idle = 1'b0;
      random_phase(PHASE_ITEMS);
    end

    evt_if.valid <= 1'b0;
    while (tracker.pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_words.size() == 0)
      $display("tb_digitizer_event_framer: PASS");
    else
      $display("tb_digitizer_event_framer: FAIL");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/def_pkg.sv
rtl/core/def_in_if.sv
rtl/core/def_out_if.sv
rtl/core/def_ctrl.sv
rtl/core/def_dp.sv
rtl/core/digitizer_event_framer.sv
rtl/core/def_chk.sv
tb/tb_digitizer_event_framer.sv
